FILE: sv/mutex_lock_table_macros.svh
// Assertion macros used by the mutex lock table slot table (mlt_table).
`ifndef MUTEX_LOCK_TABLE_MACROS_SVH
`define MUTEX_LOCK_TABLE_MACROS_SVH

`ifndef ASSERT_OFF
// Checks that prop holds at every rising clock edge outside reset.
`define MLT_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checks that cons holds in the same cycle whenever ante holds.
`define MLT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define MLT_ASSERT(name, clk, rst_n, prop, msg)
`define MLT_ASSERT_IMP(name, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: sv/mlt_pkg.sv
// Types and constants shared by the mutex lock table modules.
package mlt_pkg;

  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned TASK_IN_W = 8;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_LOCK   = 2'd1,
    REQ_UNLOCK = 2'd2,
    REQ_DELETE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_BUSY  = 2'd1,
    ST_ERROR = 2'd2
  } status_e;

  typedef struct packed {
    req_e                 kind;
    logic [HANDLE_W-1:0]  handle;
    logic [TASK_IN_W-1:0] task_id;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] new_handle;
  } res_t;

endpackage

FILE: sv/mlt_match.sv
// Per-slot handle compare and first-one selection of matching and free slots.
module mlt_match import mlt_pkg::*; #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  logic [HANDLE_W-1:0]   slot_handle_i [SLOT_COUNT],
  input  logic [HANDLE_W-1:0]   req_handle_i,
  output logic [SLOT_COUNT-1:0] hit_oh_o,
  output logic [SLOT_COUNT-1:0] free_oh_o
);

  logic [SLOT_COUNT-1:0] hit_vec;
  logic [SLOT_COUNT-1:0] free_vec;

  // A zero request handle never matches, so free slots are never addressed.
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_vec[i]  = (slot_handle_i[i] == req_handle_i) && (req_handle_i != '0);
      free_vec[i] = (slot_handle_i[i] == '0);
    end
  end

  // Keep only the lowest set bit of each vector.
  assign hit_oh_o  = hit_vec & (~hit_vec + SLOT_COUNT'(1));
  assign free_oh_o = free_vec & (~free_vec + SLOT_COUNT'(1));

endmodule

FILE: sv/mlt_table.sv
// Slot table state, request decode and slot update.
`include "mutex_lock_table_macros.svh"

module mlt_table import mlt_pkg::*; #(
  parameter int unsigned SLOT_COUNT   = 8,
  parameter int unsigned TASK_ID_BITS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  req_t req_i,
  input  logic commit_i,
  output res_t res_o
);

  localparam int unsigned TaskExtW = (TASK_ID_BITS > TASK_IN_W) ? TASK_ID_BITS : TASK_IN_W;

  logic [HANDLE_W-1:0]     handle_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   locked_q;
  logic [TASK_ID_BITS-1:0] owner_q  [SLOT_COUNT];
  logic [HANDLE_W-1:0]     next_q;
  logic [HANDLE_W-1:0]     next_d;

  logic [SLOT_COUNT-1:0]   hit_oh;
  logic [SLOT_COUNT-1:0]   free_oh;
  logic                    hit_any;
  logic                    free_any;
  logic                    locked_hit;
  logic [TASK_ID_BITS-1:0] owner_hit;
  logic [TaskExtW-1:0]     task_ext;
  logic [TASK_ID_BITS-1:0] task_w;
  logic                    op_ok;

  mlt_match #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_match (
    .slot_handle_i (handle_q),
    .req_handle_i  (req_i.handle),
    .hit_oh_o      (hit_oh),
    .free_oh_o     (free_oh)
  );

  // Only the low TASK_ID_BITS bits of the requester are kept.
  assign task_ext = TaskExtW'(req_i.task_id);
  assign task_w   = task_ext[TASK_ID_BITS-1:0];

  assign hit_any    = |hit_oh;
  assign free_any   = |free_oh;
  assign locked_hit = |(hit_oh & locked_q);

  always_comb begin
    owner_hit = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      owner_hit = owner_hit | (owner_q[i] & {TASK_ID_BITS{hit_oh[i]}});
    end
  end

  always_comb begin
    res_o.new_handle = '0;
    res_o.status     = ST_ERROR;
    op_ok            = 1'b0;
    unique case (req_i.kind)
      REQ_CREATE: begin
        if (free_any) begin
          res_o.status     = ST_OK;
          res_o.new_handle = next_q;
          op_ok            = 1'b1;
        end
      end
      REQ_LOCK: begin
        if (hit_any && locked_hit) begin
          res_o.status = ST_BUSY;
        end else if (hit_any) begin
          res_o.status = ST_OK;
          op_ok        = 1'b1;
        end
      end
      REQ_UNLOCK: begin
        if (hit_any && locked_hit && (owner_hit == task_w)) begin
          res_o.status = ST_OK;
          op_ok        = 1'b1;
        end
      end
      REQ_DELETE: begin
        if (hit_any) begin
          res_o.status = ST_OK;
          op_ok        = 1'b1;
        end
      end
    endcase
  end

  // The handle counter skips zero when it wraps.
  assign next_d = (next_q == '1) ? HANDLE_W'(1) : next_q + HANDLE_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        handle_q[i] <= '0;
        owner_q[i]  <= '0;
      end
      locked_q <= '0;
      next_q   <= HANDLE_W'(1);
    end else if (commit_i && op_ok) begin
      unique case (req_i.kind)
        REQ_CREATE: begin
          next_q <= next_d;
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (free_oh[i]) begin
              handle_q[i] <= next_q;
              locked_q[i] <= 1'b0;
              owner_q[i]  <= '0;
            end
          end
        end
        REQ_LOCK: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (hit_oh[i]) begin
              locked_q[i] <= 1'b1;
              owner_q[i]  <= task_w;
            end
          end
        end
        REQ_UNLOCK: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (hit_oh[i]) begin
              locked_q[i] <= 1'b0;
              owner_q[i]  <= '0;
            end
          end
        end
        REQ_DELETE: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (hit_oh[i]) begin
              handle_q[i] <= '0;
              locked_q[i] <= 1'b0;
              owner_q[i]  <= '0;
            end
          end
        end
      endcase
    end
  end

  `MLT_ASSERT(a_hit_onehot0, clk_i, rst_ni, $onehot0(hit_oh), "several slots selected by handle")
  `MLT_ASSERT(a_free_onehot0, clk_i, rst_ni, $onehot0(free_oh), "several free slots selected")
  `MLT_ASSERT(a_next_nonzero, clk_i, rst_ni, next_q != '0, "handle counter reached zero")
  `MLT_ASSERT_IMP(a_create_handle, clk_i, rst_ni, (req_i.kind == REQ_CREATE) && free_any, (res_o.new_handle != '0) && (res_o.status == ST_OK), "create gave no handle")

endmodule

FILE: sv/mutex_lock_table.sv
// Top level of the mutex lock table: input register, slot table and result register.
//
//   channel  direction  handshake                  payload
//   request  in         in_valid_i / in_stall_o    req_type_i, mutex_handle_i, requester_task_i
//   result   out        out_valid_o / out_stall_i  status_o, new_handle_o
//
// A request beat is captured in the input register; once it advances, the slot
// table decodes it, updates its slots and the result is loaded into the result
// register, and one beat is taken every cycle while the result side is not stalled.
// The single-cycle rate is set by the parallel handle compare of all slots.
// After reset every slot is free, unlocked and unowned, and the handle counter is 1.
// A stalled result holds the result register; the request in the input register
// then waits and the request side is stalled until the result beat is taken.
module mutex_lock_table import mlt_pkg::*; #(
  parameter int unsigned SLOT_COUNT   = 8,
  parameter int unsigned TASK_ID_BITS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  input  logic [HANDLE_W-1:0]  mutex_handle_i,
  input  logic [TASK_IN_W-1:0] requester_task_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output status_e              status_o,
  output logic [HANDLE_W-1:0]  new_handle_o
);

  logic in_valid_q;
  req_t req_q;
  logic out_valid_q;
  res_t res_q;
  res_t res_d;
  logic advance;
  logic in_load;

  // The held request moves on when the result register is empty or is being drained.
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_load    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_valid_q || advance) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      req_q.kind    <= req_e'(req_type_i);
      req_q.handle  <= mutex_handle_i;
      req_q.task_id <= requester_task_i;
    end
  end

  mlt_table #(
    .SLOT_COUNT   (SLOT_COUNT),
    .TASK_ID_BITS (TASK_ID_BITS)
  ) u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_q),
    .commit_i (advance),
    .res_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = res_q.status;
  assign new_handle_o = res_q.new_handle;

endmodule
